### design/periodic_report_scheduler_assert.svh
// Assertion macros for the periodic report scheduler checker.
// Used by prs_checker.sv; expects a clock named clk and a reset named rst in scope.
`ifndef PERIODIC_REPORT_SCHEDULER_ASSERT_SVH
`define PERIODIC_REPORT_SCHEDULER_ASSERT_SVH

// Checked on every edge outside reset.
`define PRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define PRS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/prs_pkg.sv
// Shared types and constants of the periodic report scheduler.
// No dependencies; imported by the interfaces, the top level, the controller and the datapath.
package prs_pkg;

  localparam int NOW_W      = 40;
  localparam int DUE_W      = 41;
  localparam int PER_W      = 32;
  localparam int SID_W      = 8;
  localparam int CH_W       = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SID0    = 8'd3;

  localparam logic [PER_W-1:0] PERIOD_RESET = 32'd1000;

  localparam logic ACT_TICK       = 1'b0;
  localparam logic ACT_CMD        = 1'b1;
  localparam logic KIND_REPORT    = 1'b0;
  localparam logic KIND_ANSWER    = 1'b1;
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_ILLEGAL = 1'b1;

  typedef struct packed {
    logic            load;
    logic            visit;
    logic            flush;
    logic            answer;
    logic [CH_W-1:0] ch;
  } prs_cmd_t;

  typedef struct packed {
    logic out_free;
  } prs_sts_t;

endpackage

### design/prs_in_if.sv
// Input item channel of the periodic report scheduler.
// Depends on prs_pkg.
interface prs_in_if import prs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [NOW_W-1:0] now_ms;
  logic [SID_W-1:0] target_sid;
  logic             turn_on;

  modport source (output valid, action, now_ms, target_sid, turn_on, input ready);
  modport sink (input valid, action, now_ms, target_sid, turn_on, output ready);
endinterface

### design/prs_out_if.sv
// Result channel of the periodic report scheduler.
// Depends on prs_pkg.
interface prs_out_if import prs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [CH_W-1:0]  channel;
  logic [SID_W-1:0] sid_out;
  logic             status;
  logic             last;

  modport source (output valid, kind, channel, sid_out, status, last, input ready);
  modport sink (input valid, kind, channel, sid_out, status, last, output ready);
endinterface

### design/prs_cfg_if.sv
// Configuration write channel of the periodic report scheduler.
// Depends on prs_pkg.
interface prs_cfg_if import prs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/periodic_report_scheduler.sv
// Top level of the periodic report scheduler: controller plus datapath.
// Depends on prs_pkg, prs_in_if, prs_out_if, prs_cfg_if, prs_ctrl, prs_datapath.
//
//   port    role   carries
//   item    sink   action, now_ms, target_sid, turn_on
//   result  source kind, channel, sid_out, status, last
//   cfg     sink   index, data (always ready)
//
// A command runs as the transfer, then the answer into the output register.
// A tick runs as the transfer, one channel per cycle through the shared adder
// and comparators, then a final step that releases the last report.
// A held result stalls every answer, channel and release cycle until the output
// register frees; reset needs no clearing pass.
module periodic_report_scheduler import prs_pkg::*; #(
  parameter int NUM_CHANNELS = 3
) (
  input logic       clk,
  input logic       rst,
  prs_in_if.sink    item,
  prs_out_if.source result,
  prs_cfg_if.sink   cfg
);

  prs_cmd_t cmd;
  prs_sts_t sts;
  logic     cfg_we;

  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid && cfg.ready;

  prs_ctrl #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_action(item.action),
    .item_ready (item.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  prs_datapath #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .now_ms    (item.now_ms),
    .target_sid(item.target_sid),
    .turn_on   (item.turn_on),
    .cfg_we    (cfg_we),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .result    (result)
  );

endmodule

### design/prs_datapath.sv
// Datapath: configuration registers, channel state, one shared due-time unit,
// pending report and output register. Depends on prs_pkg and prs_out_if.
module prs_datapath import prs_pkg::*; #(
  parameter int NUM_CHANNELS = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  prs_cmd_t              cmd,
  output prs_sts_t              sts,
  input  logic [NOW_W-1:0]      now_ms,
  input  logic [SID_W-1:0]      target_sid,
  input  logic                  turn_on,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  prs_out_if.source             result
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [PER_W-1:0]        period [NUM_CHANNELS];
  logic [SID_W-1:0]        sid [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] enabled;
  logic [DUE_W-1:0]        due_time [NUM_CHANNELS];

  logic [NOW_W-1:0] now_q;
  logic [SID_W-1:0] tsid_q;
  logic             on_q;

  logic             pend_valid;
  logic [IDX_W-1:0] pend_ch;
  logic [SID_W-1:0] pend_sid;

  logic             out_valid;
  logic             out_kind;
  logic [CH_W-1:0]  out_ch;
  logic [SID_W-1:0] out_sid;
  logic             out_status;
  logic             out_last;

  logic [IDX_W-1:0] sel;
  logic [DUE_W-1:0] soonest;
  logic [DUE_W-1:0] pulled;
  logic             due;
  logic             report;
  logic             found;
  logic [IDX_W-1:0] match_idx;

  logic             push;
  logic             push_kind;
  logic [CH_W-1:0]  push_ch;
  logic [SID_W-1:0] push_sid;
  logic             push_status;
  logic             push_last;

  assign sel     = cmd.ch[IDX_W-1:0];
  assign soonest = {1'b0, now_q} + DUE_W'(period[sel]);
  assign pulled  = (due_time[sel] > soonest) ? soonest : due_time[sel];
  assign due     = {1'b0, now_q} >= pulled;
  assign report  = enabled[sel] && due;

  // The lowest-numbered channel with a matching code wins.
  always_comb begin
    found     = 1'b0;
    match_idx = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (sid[i] == tsid_q) begin
        found     = 1'b1;
        match_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    push        = 1'b0;
    push_kind   = KIND_REPORT;
    push_ch     = CH_W'(pend_ch);
    push_sid    = pend_sid;
    push_status = STATUS_OK;
    push_last   = 1'b0;
    if (cmd.answer) begin
      push        = 1'b1;
      push_kind   = KIND_ANSWER;
      push_ch     = found ? CH_W'(match_idx) : '0;
      push_sid    = found ? sid[match_idx] : tsid_q;
      push_status = found ? STATUS_OK : STATUS_ILLEGAL;
      push_last   = 1'b1;
    end else if (cmd.visit) begin
      push = report && pend_valid;
    end else if (cmd.flush) begin
      push      = pend_valid;
      push_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        period[i]   <= PERIOD_RESET;
        sid[i]      <= SID_W'(i + 1);
        due_time[i] <= '0;
      end
      enabled <= '1;
    end else begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (cfg_we && cfg_index == REG_PERIOD0 + CFG_IDX_W'(i)) begin
          period[i] <= cfg_data[PER_W-1:0];
        end
        if (cfg_we && cfg_index == REG_SID0 + CFG_IDX_W'(i)) begin
          sid[i] <= cfg_data[SID_W-1:0];
        end
      end
      if (cmd.visit && enabled[sel]) begin
        due_time[sel] <= due ? soonest : pulled;
      end
      if (cmd.answer && found) begin
        enabled[match_idx] <= on_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_q  <= now_ms;
      tsid_q <= target_sid;
      on_q   <= turn_on;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.visit && report) begin
      pend_valid <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.visit && report) begin
      pend_ch  <= sel;
      pend_sid <= sid[sel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_kind   <= push_kind;
      out_ch     <= push_ch;
      out_sid    <= push_sid;
      out_status <= push_status;
      out_last   <= push_last;
    end
  end

  assign sts.out_free = !out_valid || result.ready;

  assign result.valid   = out_valid;
  assign result.kind    = out_kind;
  assign result.channel = out_ch;
  assign result.sid_out = out_sid;
  assign result.status  = out_status;
  assign result.last    = out_last;

endmodule

### design/prs_ctrl.sv
// Controller: accepts items and sequences the datapath one channel per cycle.
// Depends on prs_pkg. A held output result stalls the channel sequence.
module prs_ctrl import prs_pkg::*; #(
  parameter int NUM_CHANNELS = 3
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  input  logic     item_action,
  output logic     item_ready,
  input  prs_sts_t sts,
  output prs_cmd_t cmd
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMD   = 2'd1;
  localparam logic [1:0] S_TICK  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [IDX_W-1:0] ch;
  logic [IDX_W-1:0] ch_next;

  always_comb begin
    state_next = state;
    ch_next    = ch;
    item_ready = 1'b0;
    cmd        = '0;
    cmd.ch     = CH_W'(ch);
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load   = 1'b1;
          ch_next    = '0;
          state_next = (item_action == ACT_CMD) ? S_CMD : S_TICK;
        end
      end
      S_CMD: begin
        if (sts.out_free) begin
          cmd.answer = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_TICK: begin
        if (sts.out_free) begin
          cmd.visit = 1'b1;
          if (ch == IDX_W'(NUM_CHANNELS - 1)) begin
            state_next = S_FLUSH;
          end else begin
            ch_next = ch + 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch    <= '0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
    end
  end

endmodule

### design/prs_checker.sv
// Port-level checks of the periodic report scheduler, bound to the top level.
// Depends on periodic_report_scheduler_assert.svh.
`include "periodic_report_scheduler_assert.svh"

module prs_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic       result_kind,
  input logic [1:0] result_channel,
  input logic       result_status,
  input logic       result_last
);

  `PRS_ASSERT_ALWAYS(a_reset_clears, rst |=> (!result_valid && item_ready), "reset state wrong")
  `PRS_ASSERT(a_result_held, (result_valid && !result_ready) |=> result_valid, "result dropped")
  `PRS_ASSERT(a_answer_last, (result_valid && result_kind) |-> result_last, "answer not last")
  `PRS_ASSERT(a_illegal_form, (result_valid && result_status) |-> (result_kind && result_channel == 2'd0), "bad illegal answer")

endmodule

bind periodic_report_scheduler prs_checker u_prs_checker (
  .clk           (clk),
  .rst           (rst),
  .item_ready    (item.ready),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .result_kind   (result.kind),
  .result_channel(result.channel),
  .result_status (result.status),
  .result_last   (result.last)
);
